>>> design/tbi_pkg.sv
// Shared types, constants and helpers of the table bilinear interpolator.
`default_nettype none

package tbi_pkg;

    // Table geometry
    localparam int MAX_BETA   = 16;
    localparam int MAX_ANISO  = 16;
    localparam int GRID_DEPTH = MAX_BETA * MAX_ANISO;
    localparam int MAX_SCAN   = (MAX_BETA > MAX_ANISO) ? MAX_BETA : MAX_ANISO;
    localparam int BETA_AW    = $clog2(MAX_BETA);
    localparam int ANISO_AW   = $clog2(MAX_ANISO);
    localparam int GRID_AW    = $clog2(GRID_DEPTH);
    localparam int SCAN_W     = $clog2(MAX_SCAN + 1);

    // Numerator: four terms of 32b * 32b * 32b
    localparam int ACC_W = 98;

    // Opcodes of an input word
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_BETA  = 2'd1;
    localparam logic [1:0] OP_ANISO = 2'd2;
    localparam logic [1:0] OP_GRID  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BETA_COUNT  = 2'd0;
    localparam logic [1:0] CFG_ANISO_COUNT = 2'd1;
    localparam logic [1:0] CFG_FUDGE       = 2'd2;

    // Multiplier operand selection
    typedef logic [2:0] t_mul_op;
    localparam t_mul_op MO_NONE = 3'd0;
    localparam t_mul_op MO_W    = 3'd1;
    localparam t_mul_op MO_LO   = 3'd2;
    localparam t_mul_op MO_HI   = 3'd3;
    localparam t_mul_op MO_DEN  = 3'd4;
    localparam t_mul_op MO_FUD  = 3'd5;

    // Accumulator action
    typedef logic [1:0] t_acc_op;
    localparam t_acc_op AC_NONE = 2'd0;
    localparam t_acc_op AC_CLR  = 2'd1;
    localparam t_acc_op AC_LO   = 2'd2;
    localparam t_acc_op AC_HI   = 2'd3;

    // Kind of result word
    typedef logic [1:0] t_kind;
    localparam t_kind K_NORM  = 2'd0;
    localparam t_kind K_BELOW = 2'd1;
    localparam t_kind K_ZERO  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [31:0] beta_query;
        logic [31:0] aniso_query;
    } t_in_word;

    typedef struct packed {
        logic [31:0] coefficient;
        logic        below_table;
        logic        beta_capped;
        logic        aniso_capped;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic       load_query;
        logic       scan_clr;
        logic       scan_step;
        logic       cap;
        logic       rd_hi;
        logic       lat_lo;
        logic       lat_hi;
        logic       chk;
        logic [1:0] g_rd;
        logic       g_lat;
        logic [1:0] g_lat_sel;
        t_mul_op    mul_op;
        logic [1:0] term;
        t_acc_op    acc_op;
        logic       div_init;
        logic       div_step;
        logic       out_load;
        t_kind      out_kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic not_found;
        logic bin_bad;
        logic out_full;
    } t_sts;

    // Clamp a count register to [2, depth]
    function automatic logic [4:0] eff_count(logic [4:0] c, int depth);
        logic [4:0] r;
        if (c < 5'd2) begin
            r = 5'd2;
        end else if (int'(c) > depth) begin
            r = 5'(depth);
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/tbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/tbi_ctrl.sv
// Sequencer of the interpolator: steps one query through search, fetch and arithmetic.
`default_nettype none

module tbi_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_is_query,
    input  wire tbi_pkg::t_sts i_sts,
    output tbi_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);
    import tbi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_CAP  = 4'd2;
    localparam logic [3:0] S_RD1  = 4'd3;
    localparam logic [3:0] S_RD2  = 4'd4;
    localparam logic [3:0] S_RD3  = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_GRD  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_FUD  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic [5:0] GRD_LAST = 6'd4;
    localparam logic [5:0] MUL_LAST = 6'd13;
    localparam logic [5:0] DIV_LAST = 6'd31;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    t_kind      r_kind, n_kind;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kind  <= K_NORM;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kind  = r_kind;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_is_query) begin
                    w_cmd.load_query = 1'b1;
                    w_cmd.scan_clr   = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                w_cmd.cap = 1'b1;
                if (i_sts.not_found) begin
                    n_kind  = K_BELOW;
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                w_cmd.rd_hi  = 1'b1;
                w_cmd.lat_lo = 1'b1;
                n_state      = S_RD3;
            end
            S_RD3: begin
                w_cmd.lat_hi = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                w_cmd.chk = 1'b1;
                n_cnt     = '0;
                if (i_sts.bin_bad) begin
                    n_kind  = K_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_GRD;
                end
            end
            S_GRD: begin
                // issue four grid reads, latch each in the cycle after its read
                w_cmd.g_rd      = r_cnt[1:0];
                w_cmd.g_lat     = (r_cnt != '0);
                w_cmd.g_lat_sel = 2'(r_cnt - 6'd1);
                w_cmd.acc_op    = AC_CLR;
                if (r_cnt == GRD_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_MUL: begin
                // per term: weight, low half times grid, high half times grid
                unique case (r_cnt[3:0])
                    4'd0:  begin w_cmd.mul_op = MO_W;  w_cmd.term = 2'd0; end
                    4'd1:  begin w_cmd.mul_op = MO_LO; w_cmd.term = 2'd0; end
                    4'd2:  begin
                        w_cmd.mul_op = MO_HI; w_cmd.term = 2'd0; w_cmd.acc_op = AC_LO;
                    end
                    4'd3:  begin
                        w_cmd.mul_op = MO_W;  w_cmd.term = 2'd1; w_cmd.acc_op = AC_HI;
                    end
                    4'd4:  begin w_cmd.mul_op = MO_LO; w_cmd.term = 2'd1; end
                    4'd5:  begin
                        w_cmd.mul_op = MO_HI; w_cmd.term = 2'd1; w_cmd.acc_op = AC_LO;
                    end
                    4'd6:  begin
                        w_cmd.mul_op = MO_W;  w_cmd.term = 2'd2; w_cmd.acc_op = AC_HI;
                    end
                    4'd7:  begin w_cmd.mul_op = MO_LO; w_cmd.term = 2'd2; end
                    4'd8:  begin
                        w_cmd.mul_op = MO_HI; w_cmd.term = 2'd2; w_cmd.acc_op = AC_LO;
                    end
                    4'd9:  begin
                        w_cmd.mul_op = MO_W;  w_cmd.term = 2'd3; w_cmd.acc_op = AC_HI;
                    end
                    4'd10: begin w_cmd.mul_op = MO_LO; w_cmd.term = 2'd3; end
                    4'd11: begin
                        w_cmd.mul_op = MO_HI; w_cmd.term = 2'd3; w_cmd.acc_op = AC_LO;
                    end
                    4'd12: begin w_cmd.mul_op = MO_DEN; w_cmd.acc_op = AC_HI; end
                    default: begin w_cmd.div_init = 1'b1; end
                endcase
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FUD;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_FUD: begin
                w_cmd.mul_op = MO_FUD;
                n_kind       = K_NORM;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_kind = r_kind;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> design/tbi_dp.sv
// Datapath of the interpolator: tables, search, shared multiplier, divider, output register.
`default_nettype none

module tbi_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tbi_pkg::t_in_word i_in_word,
    input  wire logic              i_in_accept,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    input  wire tbi_pkg::t_cmd     i_cmd,
    output tbi_pkg::t_sts          o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tbi_pkg::t_out_word     o_out_word
);
    import tbi_pkg::*;

    // Configuration registers
    logic [4:0]  r_bcnt, r_acnt;
    logic [31:0] r_fudge;
    logic [4:0]  w_bc, w_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt  <= 5'd16;
            r_acnt  <= 5'd16;
            r_fudge <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_BETA_COUNT) r_bcnt <= i_cfg_data[4:0];
            if (i_cfg_index == CFG_ANISO_COUNT) r_acnt <= i_cfg_data[4:0];
            if (i_cfg_index == CFG_FUDGE) r_fudge <= i_cfg_data;
        end
    end

    assign w_bc = eff_count(r_bcnt, MAX_BETA);
    assign w_ac = eff_count(r_acnt, MAX_ANISO);

    // Table memories, written straight from accepted write words
    logic                we_beta, we_aniso, we_grid;
    logic [BETA_AW-1:0]  w_beta_ra;
    logic [ANISO_AW-1:0] w_aniso_ra;
    logic [GRID_AW-1:0]  w_grid_ra;
    logic [31:0]         w_beta_rd, w_aniso_rd, w_grid_rd;

    assign we_beta  = i_in_accept && (i_in_word.opcode == OP_BETA)
                      && (int'(i_in_word.entry_index) < MAX_BETA);
    assign we_aniso = i_in_accept && (i_in_word.opcode == OP_ANISO)
                      && (int'(i_in_word.entry_index) < MAX_ANISO);
    assign we_grid  = i_in_accept && (i_in_word.opcode == OP_GRID)
                      && (int'(i_in_word.entry_index) < GRID_DEPTH);

    tbi_ram #(.WIDTH(32), .DEPTH(MAX_BETA)) u_beta_ram (
        .i_clk   (i_clk),
        .i_we    (we_beta),
        .i_waddr (BETA_AW'(i_in_word.entry_index)),
        .i_wdata (i_in_word.entry_value),
        .i_raddr (w_beta_ra),
        .o_rdata (w_beta_rd)
    );

    tbi_ram #(.WIDTH(32), .DEPTH(MAX_ANISO)) u_aniso_ram (
        .i_clk   (i_clk),
        .i_we    (we_aniso),
        .i_waddr (ANISO_AW'(i_in_word.entry_index)),
        .i_wdata (i_in_word.entry_value),
        .i_raddr (w_aniso_ra),
        .o_rdata (w_aniso_rd)
    );

    tbi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (we_grid),
        .i_waddr (GRID_AW'(i_in_word.entry_index)),
        .i_wdata (i_in_word.entry_value),
        .i_raddr (w_grid_ra),
        .o_rdata (w_grid_rd)
    );

    // Query and axis search state
    logic [31:0]         r_bq, r_aq;
    logic [SCAN_W-1:0]   r_scan, r_prev;
    logic                r_pv, r_fb, r_fa, r_bcap, r_acap;
    logic [BETA_AW-1:0]  r_bi;
    logic [ANISO_AW-1:0] r_ai;
    logic [31:0]         r_b1, r_b2, r_a1, r_a2;
    logic [31:0]         r_dbh, r_dbl, r_dah, r_dal, r_dbw, r_daw;
    logic [GRID_AW-1:0]  r_base;
    logic [31:0]         r_n [4];

    // Axis read address: scan index, or bin bottom / top
    always_comb begin
        if (i_cmd.scan_step) begin
            w_beta_ra  = BETA_AW'(r_scan);
            w_aniso_ra = ANISO_AW'(r_scan);
        end else if (i_cmd.rd_hi) begin
            w_beta_ra  = r_bi + BETA_AW'(1);
            w_aniso_ra = r_ai + ANISO_AW'(1);
        end else begin
            w_beta_ra  = r_bi;
            w_aniso_ra = r_ai;
        end
    end

    // Grid read address: the four corners of the cell
    always_comb begin
        unique case (i_cmd.g_rd)
            2'd0: w_grid_ra = r_base;
            2'd1: w_grid_ra = r_base + GRID_AW'(1);
            2'd2: w_grid_ra = r_base + GRID_AW'(w_ac);
            default: w_grid_ra = r_base + GRID_AW'(w_ac) + GRID_AW'(1);
        endcase
    end

    // Search: remember the last entry at or below the query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_fb   <= 1'b0;
            r_fa   <= 1'b0;
            r_bcap <= 1'b0;
            r_acap <= 1'b0;
            r_scan <= '0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
                r_pv   <= 1'b0;
                r_fb   <= 1'b0;
                r_fa   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + SCAN_W'(1);
                r_prev <= r_scan;
                r_pv   <= 1'b1;
                if (r_pv && (r_prev < SCAN_W'(w_bc)) && (r_bq >= w_beta_rd)) begin
                    r_bi <= BETA_AW'(r_prev);
                    r_fb <= 1'b1;
                end
                if (r_pv && (r_prev < SCAN_W'(w_ac)) && (r_aq >= w_aniso_rd)) begin
                    r_ai <= ANISO_AW'(r_prev);
                    r_fa <= 1'b1;
                end
            end
            // hold the index at the last bin when the top entry matched
            if (i_cmd.cap) begin
                r_bcap <= (r_bi == BETA_AW'(w_bc - 5'd1));
                r_acap <= (r_ai == ANISO_AW'(w_ac - 5'd1));
                if (r_bi == BETA_AW'(w_bc - 5'd1)) r_bi <= BETA_AW'(w_bc - 5'd2);
                if (r_ai == ANISO_AW'(w_ac - 5'd1)) r_ai <= ANISO_AW'(w_ac - 5'd2);
            end
        end
    end

    // Bin edges, capped query, distances and cell base
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_bq <= i_in_word.beta_query;
            r_aq <= i_in_word.aniso_query;
        end
        if (i_cmd.lat_lo) begin
            r_b1 <= w_beta_rd;
            r_a1 <= w_aniso_rd;
        end
        if (i_cmd.lat_hi) begin
            r_b2 <= w_beta_rd;
            r_a2 <= w_aniso_rd;
            if (r_bcap) r_bq <= w_beta_rd;
            if (r_acap) r_aq <= w_aniso_rd;
        end
        if (i_cmd.chk) begin
            r_dbh  <= r_b2 - r_bq;
            r_dbl  <= r_bq - r_b1;
            r_dah  <= r_a2 - r_aq;
            r_dal  <= r_aq - r_a1;
            r_dbw  <= r_b2 - r_b1;
            r_daw  <= r_a2 - r_a1;
            r_base <= GRID_AW'(GRID_AW'(r_bi) * GRID_AW'(w_ac)) + GRID_AW'(r_ai);
        end
        if (i_cmd.g_lat) begin
            r_n[i_cmd.g_lat_sel] <= w_grid_rd;
        end
    end

    // Shared 32x32 multiplier and numerator accumulator
    logic [63:0]      r_prod;
    logic [31:0]      r_whi;
    logic [ACC_W-1:0] r_acc;
    logic [31:0]      w_ma, w_mb, w_db_t, w_da_t;
    logic [31:0]      r_dq;
    logic [63:0]      r_den, r_rem;

    assign w_db_t = i_cmd.term[1] ? r_dbl : r_dbh;
    assign w_da_t = i_cmd.term[0] ? r_dal : r_dah;

    always_comb begin
        unique case (i_cmd.mul_op)
            MO_W:   begin w_ma = w_db_t;         w_mb = w_da_t;           end
            MO_LO:  begin w_ma = r_prod[31:0];   w_mb = r_n[i_cmd.term];  end
            MO_HI:  begin w_ma = r_whi;          w_mb = r_n[i_cmd.term];  end
            MO_DEN: begin w_ma = r_dbw;          w_mb = r_daw;            end
            MO_FUD: begin w_ma = r_dq;           w_mb = r_fudge;          end
            default: begin w_ma = '0;            w_mb = '0;               end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != MO_NONE) begin
            r_prod <= {32'd0, w_ma} * {32'd0, w_mb};
        end
        if (i_cmd.mul_op == MO_LO) begin
            r_whi <= r_prod[63:32];
        end
        unique case (i_cmd.acc_op)
            AC_CLR:  r_acc <= '0;
            AC_LO:   r_acc <= r_acc + ACC_W'(r_prod);
            AC_HI:   r_acc <= r_acc + (ACC_W'(r_prod) << 32);
            default: r_acc <= r_acc;
        endcase
    end

    // Restoring divider, one quotient bit a cycle; the mean fits 32 bits
    logic [64:0] w_r2, w_sub;
    logic        w_ge;

    assign w_r2  = {r_rem, r_dq[31]};
    assign w_sub = w_r2 - {1'b0, r_den};
    assign w_ge  = (w_r2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_den <= r_prod;
            r_rem <= r_acc[32 +: 64];
            r_dq  <= r_acc[31:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_sub[63:0] : w_r2[63:0];
            r_dq  <= {r_dq[30:0], w_ge};
        end
    end

    // Output register
    logic      r_ovalid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                K_BELOW: begin
                    r_out.coefficient  <= '0;
                    r_out.below_table  <= 1'b1;
                    r_out.beta_capped  <= 1'b0;
                    r_out.aniso_capped <= 1'b0;
                end
                K_ZERO: begin
                    r_out.coefficient  <= '0;
                    r_out.below_table  <= 1'b0;
                    r_out.beta_capped  <= r_bcap;
                    r_out.aniso_capped <= r_acap;
                end
                default: begin
                    // Q16.16 product, saturate above 32 bits
                    r_out.coefficient  <= (r_prod[63:48] != 16'd0) ? '1 : r_prod[47:16];
                    r_out.below_table  <= 1'b0;
                    r_out.beta_capped  <= r_bcap;
                    r_out.aniso_capped <= r_acap;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    // Status back to the controller
    assign o_sts.scan_done = (r_scan == SCAN_W'(MAX_SCAN));
    assign o_sts.not_found = !(r_fb && r_fa);
    assign o_sts.bin_bad   = (r_b2 <= r_b1) || (r_a2 <= r_a1);
    assign o_sts.out_full  = r_ovalid && i_out_stall;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_ovalid && i_out_stall))
        else $error("result loaded over a stalled result");

    // Partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // After capping, the bin top lies inside the valid range
    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cap && r_fb && r_fa) |=>
            ((int'(r_bi) + 1 < int'(w_bc)) && (int'(r_ai) + 1 < int'(w_ac))))
        else $error("bin index out of range after capping");

endmodule

`default_nettype wire

>>> design/table_bilinear_interpolator_top.sv
// Top level of the table bilinear interpolator: controller plus datapath.
//
// Usage:
//   Input words (i_in_word) carry an opcode. Write words (beta axis, anisotropy
//   axis, grid) are taken one per cycle while the block is idle and update the
//   tables at once; they produce no result word. A query word returns exactly
//   one result word on o_out_word.
//   After a query is accepted, o_out_valid rises once these steps are done:
//   a full-depth scan of both axis memories (one entry a cycle), capping,
//   the bin edge reads, the bin check, the grid reads, a
//   multiply-accumulate phase on the one shared 32x32 multiplier,
//   a restoring divider, the fudge multiply and the output load.
//   A query below a table goes to the output load straight after capping,
//   one on an empty bin straight after the bin check. The input side stalls
//   while a query is in progress, so the next word is taken only once the
//   query has loaded its result. The result waits in an output register;
//   the next word is accepted while it waits. A finished query that finds
//   the register still stalled holds until the receiver drops i_out_stall.
//   Configuration writes (i_cfg_wr_en) are registered; the user must issue
//   them only while the block is idle, which the block itself does not enforce.
//   Reset (i_rst_n low, synchronous) empties the output register, returns the
//   sequencer to idle and restores the count and fudge registers; table
//   contents are undefined until written.
`default_nettype none

module table_bilinear_interpolator_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tbi_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tbi_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import tbi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_stall;
    logic w_in_accept;

    // Input word handshake
    assign w_in_accept = i_in_valid && !w_stall;
    assign o_in_stall  = w_stall;

    tbi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_query (i_in_word.opcode == OP_QUERY),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (w_stall)
    );

    tbi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_in_accept (w_in_accept),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

>>> verif/table_bilinear_interpolator_top_tb.sv
// Testbench of the table bilinear interpolator: directed and random words against a predictor.
`timescale 1ns / 100ps

module table_bilinear_interpolator_top_tb;
    import tbi_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = CFG_BETA_COUNT;
    logic [31:0] i_cfg_data = '0;

    table_bilinear_interpolator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of tables and registers
    logic [31:0] beta_tab [MAX_BETA];
    logic [31:0] aniso_tab [MAX_ANISO];
    logic [31:0] grid_tab [GRID_DEPTH];
    logic [4:0]  beta_cnt_reg;
    logic [4:0]  aniso_cnt_reg;
    logic [31:0] fudge_reg;

    t_out_word   pending_coeffs [$];
    int          errors = 0;
    bit          idle_on = 1'b1;
    bit          long_hold_req = 1'b0;
    int          hold_left = 0;
    int          burst_left = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp_count(logic [4:0] c, int depth);
        if (c < 2) return 2;
        if (c > depth) return depth;
        return c;
    endfunction

    // Last index at or below x; -1 when none
    function automatic int search_beta(logic [31:0] x, int cnt);
        int k = -1;
        for (int i = 0; i < cnt; i++) if (x >= beta_tab[i]) k = i;
        return k;
    endfunction

    function automatic int search_aniso(logic [31:0] x, int cnt);
        int k = -1;
        for (int i = 0; i < cnt; i++) if (x >= aniso_tab[i]) k = i;
        return k;
    endfunction

    function automatic t_out_word interp_coeff(t_in_word w);
        t_out_word   r = '0;
        int          bc, ac, bi, ai;
        logic [31:0] b, a, b1, b2, a1, a2;
        logic [127:0] num, den, q, p;
        bc = clamp_count(beta_cnt_reg, MAX_BETA);
        ac = clamp_count(aniso_cnt_reg, MAX_ANISO);
        b = w.beta_query;
        a = w.aniso_query;
        bi = search_beta(b, bc);
        ai = search_aniso(a, ac);
        if (bi < 0 || ai < 0) begin
            r.below_table = 1'b1;
            return r;
        end
        if (bi >= bc - 1) begin
            bi = bc - 2;
            b = beta_tab[bi + 1];
            r.beta_capped = 1'b1;
        end
        if (ai >= ac - 1) begin
            ai = ac - 2;
            a = aniso_tab[ai + 1];
            r.aniso_capped = 1'b1;
        end
        b1 = beta_tab[bi];
        b2 = beta_tab[bi + 1];
        a1 = aniso_tab[ai];
        a2 = aniso_tab[ai + 1];
        if (b2 <= b1 || a2 <= a1) return r;
        num = 128'(b2 - b) * 128'(a2 - a) * 128'(grid_tab[bi * ac + ai])
            + 128'(b2 - b) * 128'(a - a1) * 128'(grid_tab[bi * ac + ai + 1])
            + 128'(b - b1) * 128'(a2 - a) * 128'(grid_tab[(bi + 1) * ac + ai])
            + 128'(b - b1) * 128'(a - a1) * 128'(grid_tab[(bi + 1) * ac + ai + 1]);
        den = 128'(b2 - b1) * 128'(a2 - a1);
        q = num / den;
        if (q > 128'hFFFF_FFFF) q = 128'hFFFF_FFFF;
        p = (q * 128'(fudge_reg)) >> 16;
        if (p > 128'hFFFF_FFFF) p = 128'hFFFF_FFFF;
        r.coefficient = p[31:0];
        return r;
    endfunction

    function automatic void apply_word(t_in_word w);
        case (w.opcode)
            OP_BETA:  if (w.entry_index < MAX_BETA) beta_tab[w.entry_index] = w.entry_value;
            OP_ANISO: if (w.entry_index < MAX_ANISO) aniso_tab[w.entry_index] = w.entry_value;
            OP_GRID:  if (w.entry_index < GRID_DEPTH) grid_tab[w.entry_index] = w.entry_value;
            default:  pending_coeffs = {pending_coeffs, interp_coeff(w)};
        endcase
    endfunction

    // Send one word, with an optional random gap in front
    task automatic send_word(t_in_word w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        apply_word(w);
    endtask

    task automatic send_query(logic [31:0] b, logic [31:0] a);
        t_in_word w = '0;
        w.opcode = OP_QUERY;
        w.entry_index = 8'($urandom());
        w.entry_value = $urandom();
        w.beta_query = b;
        w.aniso_query = a;
        send_word(w);
    endtask

    task automatic send_write(logic [1:0] op, logic [7:0] idx, logic [31:0] val);
        t_in_word w;
        w.opcode = op;
        w.entry_index = idx;
        w.entry_value = val;
        w.beta_query = $urandom();
        w.aniso_query = $urandom();
        send_word(w);
    endtask

    // Wait for all results, then let a trailing write finish
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_coeffs.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BETA_COUNT:  beta_cnt_reg = val[4:0];
            CFG_ANISO_COUNT: aniso_cnt_reg = val[4:0];
            default:         fudge_reg = val;
        endcase
    endtask

    // Result check
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (o_out_valid && !i_out_stall) begin
            if (pending_coeffs.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", o_out_word);
            end else begin
                exp_w = pending_coeffs.pop_front();
                if (o_out_word.coefficient !== exp_w.coefficient
                    || o_out_word.below_table !== exp_w.below_table
                    || o_out_word.beta_capped !== exp_w.beta_capped
                    || o_out_word.aniso_capped !== exp_w.aniso_capped) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h %0d%0d%0d got %h %0d%0d%0d",
                                 exp_w.coefficient, exp_w.below_table, exp_w.beta_capped,
                                 exp_w.aniso_capped, o_out_word.coefficient,
                                 o_out_word.below_table, o_out_word.beta_capped,
                                 o_out_word.aniso_capped);
                end
            end
        end
    end

    // Receiver stall: long hold on request, random bursts otherwise
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Ascending axes with random gaps, axis start above zero
    task automatic load_tables();
        logic [31:0] v;
        v = $urandom_range(1, 32'h0100_0000);
        for (int i = 0; i < MAX_BETA; i++) begin
            send_write(OP_BETA, 8'(i), v);
            v += $urandom_range(1, 32'h0800_0000);
        end
        v = $urandom_range(1, 32'h0100_0000);
        for (int i = 0; i < MAX_ANISO; i++) begin
            send_write(OP_ANISO, 8'(i), v);
            v += $urandom_range(1, 32'h0800_0000);
        end
        for (int i = 0; i < GRID_DEPTH; i++) send_write(OP_GRID, 8'(i), $urandom());
    endtask

    function automatic logic [31:0] beta_pick();
        int i = $urandom_range(0, MAX_BETA - 1);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return beta_tab[i];
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 32'h0100_0000);
            default: return beta_tab[i] + $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] aniso_pick();
        int i = $urandom_range(0, MAX_ANISO - 1);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return aniso_tab[i];
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 32'h0100_0000);
            default: return aniso_tab[i] + $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    // Edges of both axes, capping, empty bin, ignored writes
    task automatic test_directed();
        logic [31:0] keep;
        send_query(32'h0, 32'h0);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'hFFFF_FFFF, aniso_tab[3] + 1);
        send_query(beta_tab[7] + 5, 32'h0);
        send_query(beta_tab[0], aniso_tab[0]);
        send_query(beta_tab[15], aniso_tab[15]);
        send_query(beta_tab[14], aniso_tab[14]);
        send_query(beta_tab[0] - 1, aniso_tab[5]);
        send_query(beta_tab[4] + 3, aniso_tab[9] + 7);
        send_write(OP_BETA, 8'd16, 32'hFFFF_FFFF);
        send_write(OP_ANISO, 8'd255, 32'h0);
        send_write(OP_BETA, 8'd255, 32'h0);
        send_write(OP_GRID, 8'd255, 32'hFFFF_FFFF);
        send_write(OP_GRID, 8'd0, 32'hFFFF_FFFF);
        send_query(beta_tab[0], aniso_tab[0]);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // empty beta bin, then restore
        keep = beta_tab[5];
        send_write(OP_BETA, 8'd5, beta_tab[4]);
        send_query(beta_tab[4], aniso_tab[2] + 1);
        send_write(OP_BETA, 8'd5, keep);
        keep = aniso_tab[8];
        send_write(OP_ANISO, 8'd8, aniso_tab[7]);
        send_query(beta_tab[2], aniso_tab[7] + 2);
        send_write(OP_ANISO, 8'd8, keep);
        send_query(beta_tab[5] - 1, aniso_tab[8] - 1);
    endtask

    task automatic random_words(int n);
        int          i;
        logic [31:0] lo, hi;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0: send_write(2'($urandom()), 8'($urandom()), $urandom());
                1, 2: begin
                    i = $urandom_range(0, MAX_BETA - 1);
                    lo = (i == 0) ? 32'h0 : beta_tab[i - 1];
                    hi = (i == MAX_BETA - 1) ? 32'hFFFF_FFFF : beta_tab[i + 1];
                    send_write(OP_BETA, 8'(i), (hi > lo) ? $urandom_range(lo, hi) : lo);
                end
                3, 4: begin
                    i = $urandom_range(0, MAX_ANISO - 1);
                    lo = (i == 0) ? 32'h0 : aniso_tab[i - 1];
                    hi = (i == MAX_ANISO - 1) ? 32'hFFFF_FFFF : aniso_tab[i + 1];
                    send_write(OP_ANISO, 8'(i), (hi > lo) ? $urandom_range(lo, hi) : lo);
                end
                5, 6: send_write(OP_GRID, 8'($urandom()), $urandom());
                default: send_query(beta_pick(), aniso_pick());
            endcase
        end
    endtask

    // Count and fudge sweep, extremes first
    task automatic test_config_sweep();
        logic [31:0] counts [6] = '{32'd2, 32'd16, 32'd0, 32'd31, 32'd1, 32'd17};
        logic [31:0] fudges [4] = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd0};
        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_BETA_COUNT, counts[k]);
            write_reg(CFG_ANISO_COUNT, counts[5 - k]);
            write_reg(CFG_FUDGE, fudges[k % 4]);
            send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_query(beta_tab[1], aniso_tab[0]);
            random_words(40);
        end
        for (int k = 0; k < 10; k++) begin
            write_reg(CFG_BETA_COUNT, $urandom_range(2, 16));
            write_reg(CFG_ANISO_COUNT, $urandom_range(2, 16));
            write_reg(CFG_FUDGE, $urandom());
            random_words(45);
        end
        write_reg(CFG_BETA_COUNT, 32'hFFFF_FFF0);
        write_reg(CFG_ANISO_COUNT, 32'd16);
        write_reg(CFG_FUDGE, 32'h0001_0000);
    endtask

    // Receiver holds off, sender keeps pushing until input stalls
    task automatic test_backpressure();
        long_hold_req <= 1'b1;
        for (int k = 0; k < 6; k++) send_query(beta_pick(), aniso_pick());
        drain();
        random_words(30);
    endtask

    task automatic test_random_tail();
        random_words(250);
        drain();
        idle_on = 1'b0;
        random_words(150);
    endtask

    initial begin
        beta_cnt_reg  = 5'd16;
        aniso_cnt_reg = 5'd16;
        fudge_reg     = 32'd65536;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_tables();
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random_tail();
        drain();
        errors += pending_coeffs.size();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
